// ===== hdl/tdp_pkg.sv =====
package tdp_pkg;

    // Longest line tracked by the byte position counter
    localparam int MAX_LINE = 255;
    localparam int POS_W    = $clog2(MAX_LINE + 1);

    // Character codes
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_SP = 8'h20;

    // Field limits
    localparam logic [7:0] LABEL_MAX  = 8'd8;
    localparam logic [7:0] TS_LEN     = 8'd13;
    localparam logic [7:0] LEN_SAT    = 8'd255;
    localparam logic [1:0] FIELD_LAST = 2'd3;

    // Field indexes
    localparam logic [1:0] FIELD_LABEL = 2'd0;
    localparam logic [1:0] FIELD_ONE   = 2'd1;
    localparam logic [1:0] FIELD_TWO   = 2'd2;

    // Expected separator counts
    localparam logic [7:0] SEPS_PLAIN = 8'd2;
    localparam logic [7:0] SEPS_TS    = 8'd3;

    // Configuration register map (index = paddr[5:3])
    localparam int PADDR_W = 6;
    localparam logic [2:0] REG_HISTORIC  = 3'd0;
    localparam logic [2:0] REG_WITH_TS   = 3'd1;
    localparam logic [2:0] REG_LABEL     = 3'd2;
    localparam logic [2:0] REG_LABEL_SZ  = 3'd3;
    localparam logic [2:0] REG_DATA_SZ   = 3'd4;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_TS    = 2'd1,
        KIND_FINAL = 2'd2
    } kind_t;

    // Verdict codes, smaller code wins
    typedef enum logic [3:0] {
        VERD_OK        = 4'd0,
        VERD_NO_LF     = 4'd1,
        VERD_LABEL_LEN = 4'd2,
        VERD_SEP_COUNT = 4'd3,
        VERD_MISMATCH  = 4'd4,
        VERD_TS_LEN    = 4'd5,
        VERD_SEASON    = 4'd6,
        VERD_DATA_LEN  = 4'd7,
        VERD_BAD_CHAR  = 4'd8
    } verdict_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic        historic_mode;
        logic        with_timestamp;
        logic [63:0] expected_label;
        logic [3:0]  label_size;
        logic [6:0]  data_size;
    } cfg_t;

    // Classified byte passed from front to back
    typedef struct packed {
        logic       first;
        logic       last;
        logic       sep;
        logic       lf;
        logic       printable;
        logic       season_ok;
        logic [7:0] chr;
    } tok_t;

endpackage

// ===== hdl/tdp_if.sv =====
interface tdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_set;

    modport source (output valid, output char_in, output end_of_set, input ready);
    modport sink   (input valid, input char_in, input end_of_set, output ready);
endinterface

interface tdp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [3:0] verdict;
    logic       is_final;

    modport source (output valid, output kind, output char_out, output verdict,
                    output is_final, input ready);
    modport sink   (input valid, input kind, input char_out, input verdict,
                    input is_final, output ready);
endinterface

// ===== hdl/tic_dataset_parser_top.sv =====
// Channel  | Dir | Beat payload                          | Handshake
// dataset  | in  | char_in[7:0], end_of_set              | valid/ready
// report   | out | kind[1:0], char_out[7:0], verdict[3:0], is_final | valid/ready
// apb      | in  | paddr[5:0], pwdata[63:0] -> prdata     | psel/penable, pready=1
//
// One byte per cycle sustained unless report stalls; each byte crosses the
// 2-entry queue and is resolved by the back end, which registers its result.
// The back end updates field state and loads the output register in one step.
// Reset (rst_n low, async) clears the queue, the byte position and all field state.
// A stalled report fills the queue; dataset.ready drops only when it is full.
module tic_dataset_parser_top (
    input  logic                         clk,
    input  logic                         rst_n,
    tdp_in_if.sink                       dataset,
    tdp_out_if.source                    report,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tdp_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);

    tdp_pkg::cfg_t cfg;
    tdp_pkg::tok_t front_tok;
    tdp_pkg::tok_t head_tok;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    tdp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tdp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .dataset (dataset),
        .q_full  (q_full),
        .push    (push),
        .tok     (front_tok)
    );

    tdp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (front_tok),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (head_tok)
    );

    tdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tok_valid (q_valid),
        .tok       (head_tok),
        .pop       (pop),
        .report    (report)
    );

endmodule

// ===== hdl/tdp_regs.sv =====
module tdp_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tdp_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    output tdp_pkg::cfg_t                cfg
);

    tdp_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];
    assign cfg     = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.historic_mode  <= 1'b0;
            cfg_reg.with_timestamp <= 1'b0;
            cfg_reg.expected_label <= '0;
            cfg_reg.label_size     <= 4'd1;
            cfg_reg.data_size      <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                tdp_pkg::REG_HISTORIC: cfg_reg.historic_mode  <= pwdata[0];
                tdp_pkg::REG_WITH_TS:  cfg_reg.with_timestamp <= pwdata[0];
                tdp_pkg::REG_LABEL:    cfg_reg.expected_label <= pwdata;
                tdp_pkg::REG_LABEL_SZ: cfg_reg.label_size     <= pwdata[3:0];
                tdp_pkg::REG_DATA_SZ:  cfg_reg.data_size      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            tdp_pkg::REG_HISTORIC: prdata = {63'd0, cfg_reg.historic_mode};
            tdp_pkg::REG_WITH_TS:  prdata = {63'd0, cfg_reg.with_timestamp};
            tdp_pkg::REG_LABEL:    prdata = cfg_reg.expected_label;
            tdp_pkg::REG_LABEL_SZ: prdata = {60'd0, cfg_reg.label_size};
            tdp_pkg::REG_DATA_SZ:  prdata = {57'd0, cfg_reg.data_size};
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== hdl/tdp_front.sv =====
module tdp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  tdp_pkg::cfg_t    cfg,
    tdp_in_if.sink           dataset,
    input  logic             q_full,
    output logic             push,
    output tdp_pkg::tok_t    tok
);

    logic [tdp_pkg::POS_W-1:0] pos_reg;
    logic [tdp_pkg::POS_W-1:0] pos_next;
    logic [7:0]                sep_char;

    assign dataset.ready = !q_full;
    assign push          = dataset.valid && !q_full;
    assign sep_char      = cfg.historic_mode ? tdp_pkg::CH_SP : tdp_pkg::CH_HT;

    // Classify the byte
    always_comb
    begin
        tok.first     = (pos_reg == '0);
        tok.last      = dataset.end_of_set;
        tok.sep       = (dataset.char_in == sep_char);
        tok.lf        = (dataset.char_in == tdp_pkg::CH_LF);
        tok.printable = dataset.char_in inside {[8'h20:8'h7E]};
        tok.season_ok = dataset.char_in inside {8'h45, 8'h65, 8'h48, 8'h68};
        tok.chr       = dataset.char_in;
    end

    // Advance byte position, saturate, restart after the last byte
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (dataset.end_of_set)
                pos_next = '0;
            else if (pos_reg < tdp_pkg::POS_W'(tdp_pkg::MAX_LINE))
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

// ===== hdl/tdp_queue.sv =====
module tdp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tdp_pkg::tok_t    push_tok,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output tdp_pkg::tok_t    head
);

    tdp_pkg::tok_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== hdl/tdp_back.sv =====
module tdp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tdp_pkg::cfg_t    cfg,
    input  logic             tok_valid,
    input  tdp_pkg::tok_t    tok,
    output logic             pop,
    tdp_out_if.source        report
);

    // Parse state
    logic [1:0] fi_reg,   fi_next;
    logic [7:0] len_reg,  len_next;
    logic [7:0] seps_reg, seps_next;
    logic       err1_reg, err1_next;
    logic       err2_reg, err2_next;
    logic       err5_reg, err5_next;
    logic       err7_reg, err7_next;
    logic       mism_reg, mism_next;
    logic       seas_reg, seas_next;
    logic       nprt_reg, nprt_next;

    // Output register
    logic                  out_valid_reg;
    tdp_pkg::kind_t        kind_reg,    kind_next;
    logic [7:0]            char_reg,    char_next;
    tdp_pkg::verdict_t     verdict_reg, verdict_next;
    logic                  final_reg,   final_next;
    logic                  emit;

    logic [1:0] data_field;
    logic [7:0] seps_want;
    logic [7:0] exp_char;
    logic       in_ts;

    assign pop        = tok_valid && (!out_valid_reg || report.ready);
    assign data_field = cfg.with_timestamp ? tdp_pkg::FIELD_TWO : tdp_pkg::FIELD_ONE;
    assign seps_want  = cfg.with_timestamp ? tdp_pkg::SEPS_TS : tdp_pkg::SEPS_PLAIN;
    assign exp_char   = cfg.expected_label[{len_reg[2:0], 3'b000} +: 8];
    assign in_ts      = cfg.with_timestamp && (fi_reg == tdp_pkg::FIELD_ONE);

    // Update fields and build the result for one byte
    always_comb
    begin
        fi_next      = fi_reg;
        len_next     = len_reg;
        seps_next    = seps_reg;
        err1_next    = err1_reg;
        err2_next    = err2_reg;
        err5_next    = err5_reg;
        err7_next    = err7_reg;
        mism_next    = mism_reg;
        seas_next    = seas_reg;
        nprt_next    = nprt_reg;
        emit         = 1'b0;
        kind_next    = kind_reg;
        char_next    = char_reg;
        verdict_next = verdict_reg;
        final_next   = final_reg;

        if (tok.first)
        begin
            if (!tok.lf)
                err1_next = 1'b1;
        end
        else if (tok.sep)
        begin
            // Close the current field
            if (fi_reg == tdp_pkg::FIELD_LABEL)
            begin
                if (len_reg == 8'd0 || len_reg > tdp_pkg::LABEL_MAX)
                    err2_next = 1'b1;
                if (len_reg != {4'd0, cfg.label_size})
                    mism_next = 1'b1;
            end
            else if (in_ts)
            begin
                if (len_reg != tdp_pkg::TS_LEN)
                    err5_next = 1'b1;
            end
            else if (fi_reg == data_field)
            begin
                if (len_reg != {1'b0, cfg.data_size})
                    err7_next = 1'b1;
            end
            if (seps_reg != tdp_pkg::LEN_SAT)
                seps_next = seps_reg + 8'd1;
            if (fi_reg != tdp_pkg::FIELD_LAST)
                fi_next = fi_reg + 2'd1;
            len_next = 8'd0;
        end
        else
        begin
            if (fi_reg == tdp_pkg::FIELD_LABEL)
            begin
                if (len_reg < tdp_pkg::LABEL_MAX && exp_char != tok.chr)
                    mism_next = 1'b1;
            end
            else if (in_ts)
            begin
                if (len_reg == 8'd0 && !tok.season_ok)
                    seas_next = 1'b1;
                if (!tok.last)
                begin
                    emit      = 1'b1;
                    kind_next = tdp_pkg::KIND_TS;
                end
            end
            else if (fi_reg == data_field)
            begin
                if (!tok.printable)
                    nprt_next = 1'b1;
                if (!tok.last)
                begin
                    emit      = 1'b1;
                    kind_next = tdp_pkg::KIND_DATA;
                end
            end
            if (len_reg != tdp_pkg::LEN_SAT)
                len_next = len_reg + 8'd1;
        end

        if (emit)
        begin
            char_next    = tok.chr;
            verdict_next = tdp_pkg::VERD_OK;
            final_next   = 1'b0;
        end

        // Close the dataset: lowest code wins
        if (tok.last)
        begin
            verdict_next = tdp_pkg::VERD_OK;
            if (nprt_next)
                verdict_next = tdp_pkg::VERD_BAD_CHAR;
            if (err7_next)
                verdict_next = tdp_pkg::VERD_DATA_LEN;
            if (seas_next)
                verdict_next = tdp_pkg::VERD_SEASON;
            if (err5_next)
                verdict_next = tdp_pkg::VERD_TS_LEN;
            if (mism_next)
                verdict_next = tdp_pkg::VERD_MISMATCH;
            if (seps_next != seps_want)
                verdict_next = tdp_pkg::VERD_SEP_COUNT;
            if (err2_next || fi_next == tdp_pkg::FIELD_LABEL)
                verdict_next = tdp_pkg::VERD_LABEL_LEN;
            if (err1_next)
                verdict_next = tdp_pkg::VERD_NO_LF;
            emit       = 1'b1;
            kind_next  = tdp_pkg::KIND_FINAL;
            char_next  = 8'd0;
            final_next = 1'b1;
            fi_next    = tdp_pkg::FIELD_LABEL;
            len_next   = 8'd0;
            seps_next  = 8'd0;
            err1_next  = 1'b0;
            err2_next  = 1'b0;
            err5_next  = 1'b0;
            err7_next  = 1'b0;
            mism_next  = 1'b0;
            seas_next  = 1'b0;
            nprt_next  = 1'b0;
        end
    end

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg   <= tdp_pkg::FIELD_LABEL;
            len_reg  <= 8'd0;
            seps_reg <= 8'd0;
            err1_reg <= 1'b0;
            err2_reg <= 1'b0;
            err5_reg <= 1'b0;
            err7_reg <= 1'b0;
            mism_reg <= 1'b0;
            seas_reg <= 1'b0;
            nprt_reg <= 1'b0;
        end
        else if (pop)
        begin
            fi_reg   <= fi_next;
            len_reg  <= len_next;
            seps_reg <= seps_next;
            err1_reg <= err1_next;
            err2_reg <= err2_next;
            err5_reg <= err5_next;
            err7_reg <= err7_next;
            mism_reg <= mism_next;
            seas_reg <= seas_next;
            nprt_reg <= nprt_next;
        end
    end

    // Output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= emit;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg    <= kind_next;
            char_reg    <= char_next;
            verdict_reg <= verdict_next;
            final_reg   <= final_next;
        end
    end

    assign report.valid    = out_valid_reg;
    assign report.kind     = kind_reg;
    assign report.char_out = char_reg;
    assign report.verdict  = verdict_reg;
    assign report.is_final = final_reg;

endmodule
